// File: design/prle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the pix run-length image decoder: transfer payload types,
// result codes, parser phase encoding and header constants. No dependencies.

package prle_pkg;

    // One input transfer: a file byte and the start-of-file flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_t;

    // One result transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [2:0]  channels;
        logic [7:0]  run_length;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha_or_gray;
        logic        image_done;
        logic [1:0]  error_code;
    } out_t;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_DEPTH = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RUNS   = 3'b010,
        PH_IDLE   = 3'b100
    } phase_t;

    // Header byte positions
    localparam logic [3:0] HDR_WIDTH_HI  = 4'd0;
    localparam logic [3:0] HDR_WIDTH_LO  = 4'd1;
    localparam logic [3:0] HDR_HEIGHT_HI = 4'd2;
    localparam logic [3:0] HDR_HEIGHT_LO = 4'd3;
    localparam logic [3:0] HDR_DEPTH_HI  = 4'd8;
    localparam logic [3:0] HDR_DEPTH_LO  = 4'd9;

    // Supported bit depths and their channel counts
    localparam logic [15:0] DEPTH_GRAY = 16'd8;
    localparam logic [15:0] DEPTH_RGB  = 16'd24;
    localparam logic [15:0] DEPTH_RGBA = 16'd32;

    localparam logic [2:0] CH_NONE = 3'd0;
    localparam logic [2:0] CH_GRAY = 3'd1;
    localparam logic [2:0] CH_RGB  = 3'd3;
    localparam logic [2:0] CH_RGBA = 3'd4;

    // Packet byte positions
    localparam logic [2:0] PKT_COUNT = 3'd0;
    localparam logic [2:0] PKT_BLUE  = 3'd1;
    localparam logic [2:0] PKT_GREEN = 3'd2;
    localparam logic [2:0] PKT_RED   = 3'd3;
    localparam logic [2:0] PKT_ALPHA = 3'd4;

endpackage

`default_nettype wire

// File: design/pix_run_length_image_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A finished result goes to the output register, or to the skid register while m_valid stalls.
// Throughput: one byte per cycle; s_ready drops only while two results wait downstream
// (output register and skid register both full).
// Reset: aresetn, synchronous active low; parser returns to header phase, result buffer empties.
// Depends on prle_pkg and prle_out_buf.

module pix_run_length_image_decoder_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  prle_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output prle_pkg::out_t m_data
);
    import prle_pkg::*;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    phase_t      phase_reg,     phase_next;
    logic [3:0]  hdr_idx_reg,   hdr_idx_next;
    logic [15:0] width_reg,     width_next;
    logic [15:0] height_reg,    height_next;
    logic [7:0]  depth_hi_reg,  depth_hi_next;
    logic [2:0]  chan_reg,      chan_next;
    logic [2:0]  pkt_idx_reg,   pkt_idx_next;
    logic [7:0]  count_reg,     count_next;
    logic [9:0]  run_bytes_reg, run_bytes_next;   // count * channels
    logic [7:0]  blue_reg,      blue_next;
    logic [7:0]  green_reg,     green_next;
    logic [7:0]  red_reg,       red_next;
    logic [33:0] total_reg,     total_next;       // width*height*channels
    logic [33:0] done_reg,      done_next;        // image bytes covered so far

    // width*height, refreshed every cycle; settled long before the depth bytes arrive
    logic [31:0] area_reg;

    // ---------------------------------------------------------------
    // Per-transfer decode
    // ---------------------------------------------------------------
    logic        in_fire;
    logic        restart;
    logic [7:0]  byte_in;
    phase_t      cur_phase;
    logic [3:0]  cur_idx;
    logic [2:0]  cur_pkt;
    logic [15:0] depth_word;
    logic [2:0]  chan_dec;
    logic [33:0] total_calc;
    logic        area_zero;
    logic [2:0]  pkt_last_idx;
    logic [9:0]  count_mult;
    logic [33:0] done_sum;
    logic        overflow;
    logic        fills;
    logic        res_valid;
    out_t        res;
    logic        buf_can_push;

    assign in_fire = s_valid && s_ready;
    assign s_ready = buf_can_push;
    assign restart = s_data.start_of_file;
    assign byte_in = s_data.data_byte;

    // A start flag makes this byte header byte 0 of a fresh file
    assign cur_phase = restart ? PH_HEADER : phase_reg;
    assign cur_idx   = restart ? HDR_WIDTH_HI : hdr_idx_reg;
    assign cur_pkt   = restart ? PKT_COUNT : pkt_idx_reg;

    assign depth_word = {depth_hi_reg, byte_in};
    assign area_zero  = (area_reg == 32'd0);

    always_comb begin
        case (depth_word)
            DEPTH_GRAY: chan_dec = CH_GRAY;
            DEPTH_RGB:  chan_dec = CH_RGB;
            DEPTH_RGBA: chan_dec = CH_RGBA;
            default:    chan_dec = CH_NONE;
        endcase
    end

    // area * channels: a single add at most
    always_comb begin
        case (chan_dec)
            CH_GRAY: total_calc = {2'b00, area_reg};
            CH_RGB:  total_calc = {2'b00, area_reg} + {1'b0, area_reg, 1'b0};
            CH_RGBA: total_calc = {area_reg, 2'b00};
            default: total_calc = 34'd0;
        endcase
    end

    // Packet length per channel count, and count byte scaled to image bytes
    always_comb begin
        case (chan_reg)
            CH_GRAY: begin
                pkt_last_idx = PKT_BLUE;
                count_mult   = {2'b00, byte_in};
            end
            CH_RGB: begin
                pkt_last_idx = PKT_RED;
                count_mult   = {2'b00, byte_in} + {1'b0, byte_in, 1'b0};
            end
            default: begin
                pkt_last_idx = PKT_ALPHA;
                count_mult   = {byte_in, 2'b00};
            end
        endcase
    end

    assign done_sum = done_reg + {24'd0, run_bytes_reg};
    assign overflow = (done_sum > total_reg);
    assign fills    = (done_sum == total_reg);

    // ---------------------------------------------------------------
    // Next state and result
    // ---------------------------------------------------------------
    always_comb begin
        phase_next     = cur_phase;
        hdr_idx_next   = cur_idx;
        width_next     = width_reg;
        height_next    = height_reg;
        depth_hi_next  = depth_hi_reg;
        chan_next      = restart ? CH_NONE : chan_reg;
        pkt_idx_next   = cur_pkt;
        count_next     = count_reg;
        run_bytes_next = run_bytes_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        red_next       = red_reg;
        total_next     = total_reg;
        done_next      = done_reg;
        res_valid      = 1'b0;
        res            = '0;

        case (cur_phase)
            PH_HEADER: begin
                // big-endian fields; bytes 4..7 skipped
                case (cur_idx)
                    HDR_WIDTH_HI:  width_next    = {8'h00, byte_in};
                    HDR_WIDTH_LO:  width_next    = {width_reg[7:0], byte_in};
                    HDR_HEIGHT_HI: height_next   = {8'h00, byte_in};
                    HDR_HEIGHT_LO: height_next   = {height_reg[7:0], byte_in};
                    HDR_DEPTH_HI:  depth_hi_next = byte_in;
                    default:       ;
                endcase
                hdr_idx_next = cur_idx + 4'd1;

                if (cur_idx == HDR_DEPTH_LO) begin
                    res_valid  = 1'b1;
                    chan_next  = chan_dec;
                    res.width  = width_reg;
                    res.height = height_reg;
                    res.channels = chan_dec;
                    if (chan_dec == CH_NONE) begin
                        // unsupported depth: wait for the next start flag
                        phase_next     = PH_IDLE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_DEPTH;
                    end else begin
                        total_next     = total_calc;
                        done_next      = 34'd0;
                        pkt_idx_next   = PKT_COUNT;
                        // an empty image is complete at once
                        phase_next     = area_zero ? PH_IDLE : PH_RUNS;
                        res.kind       = KIND_HEADER;
                        res.image_done = area_zero;
                        res.error_code = ERR_NONE;
                    end
                end
            end

            PH_RUNS: begin
                case (cur_pkt)
                    PKT_COUNT: begin
                        count_next     = byte_in;
                        run_bytes_next = count_mult;
                    end
                    PKT_BLUE:  blue_next  = byte_in;
                    PKT_GREEN: green_next = byte_in;
                    PKT_RED:   red_next   = byte_in;
                    default:   ;
                endcase
                pkt_idx_next = cur_pkt + 3'd1;

                if (cur_pkt == pkt_last_idx) begin
                    pkt_idx_next = PKT_COUNT;
                    done_next    = done_sum;
                    res_valid    = 1'b1;
                    res.width    = width_reg;
                    res.height   = height_reg;
                    res.channels = chan_reg;
                    if (overflow) begin
                        phase_next     = PH_IDLE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_OVERFLOW;
                    end else begin
                        if (fills) begin
                            phase_next = PH_IDLE;
                        end
                        res.kind       = KIND_RUN;
                        res.run_length = count_reg;
                        res.image_done = fills;
                        res.error_code = ERR_NONE;
                        // last byte of the packet is taken straight from the input
                        case (chan_reg)
                            CH_GRAY: begin
                                res.alpha_or_gray = byte_in;
                            end
                            CH_RGB: begin
                                res.red   = byte_in;
                                res.green = green_reg;
                                res.blue  = blue_reg;
                            end
                            default: begin
                                res.red           = red_reg;
                                res.green         = green_reg;
                                res.blue          = blue_reg;
                                res.alpha_or_gray = byte_in;
                            end
                        endcase
                    end
                end
            end

            default: ;   // idle: bytes dropped until a start flag
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_idx_reg <= HDR_WIDTH_HI;
            pkt_idx_reg <= PKT_COUNT;
            chan_reg    <= CH_NONE;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            pkt_idx_reg <= pkt_idx_next;
            chan_reg    <= chan_next;
        end
    end

    // Datapath registers: all written before they are read after any restart
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            depth_hi_reg  <= depth_hi_next;
            count_reg     <= count_next;
            run_bytes_reg <= run_bytes_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            red_reg       <= red_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
        end
        area_reg <= width_reg * height_reg;
    end

    // ---------------------------------------------------------------
    // Result buffer
    // ---------------------------------------------------------------
    prle_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire && res_valid),
        .push_data (res),
        .can_push  (buf_can_push),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: design/prle_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry result buffer (output register plus skid register).
// Depends on prle_pkg for the result type.

module prle_out_buf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  prle_pkg::out_t push_data,
    output logic           can_push,
    output logic           m_valid,
    input  logic           m_ready,
    output prle_pkg::out_t m_data
);
    import prle_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    out_t out_data_reg;
    out_t skid_data_reg;
    logic pop;

    assign pop      = out_valid_reg && m_ready;
    assign can_push = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // push only arrives while the skid entry is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/prle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the pix run-length image decoder, bound to the top level.
// Depends on prle_pkg.

module prle_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input prle_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input prle_pkg::out_t m_data
);
    import prle_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transfer dropped or changed while stalled");

    a_run_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_RUN |->
            m_data.error_code == ERR_NONE &&
            (m_data.channels == CH_GRAY || m_data.channels == CH_RGB ||
             m_data.channels == CH_RGBA))
        else $error("run result with error or bad channel count");

    // header and error results carry no run; errors never complete an image
    a_side_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_RUN |->
            m_data.run_length == 8'd0 &&
            ((m_data.kind == KIND_ERROR) ?
                (m_data.error_code != ERR_NONE && !m_data.image_done) :
                (m_data.error_code == ERR_NONE && m_data.channels != CH_NONE)))
        else $error("header or error result fields inconsistent");

endmodule

bind pix_run_length_image_decoder_unit prle_checker u_prle_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: bench/tb_pix_run_length_image_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for pix_run_length_image_decoder_unit: directed files, random files and
// a long result stall, checked against a byte-level decoder model held in the bench.
// Depends on prle_pkg and the decoder RTL.

module tb_pix_run_length_image_decoder_unit;

    import prle_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 200;     // long result stall
    localparam int unsigned DRAIN_CYCLES = 8;       // quiet cycles after the last result
    localparam int unsigned WATCHDOG_NS  = 1000000;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    pix_run_length_image_decoder_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    out_t        expected_results[$];   // decoder results still owed by the DUT
    out_t        oldest_result;
    int unsigned fail_count    = 0;
    int unsigned live_bytes    = 0;     // transfers the decoder actually parsed
    int unsigned send_idle_pct = 28;
    int unsigned recv_idle_pct = 46;
    int unsigned hold_token    = 0;     // bumped by a test to request a long stall
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;

    // ------------------------------------------------------------------
    // Decoder model: own copy of the parser state
    // ------------------------------------------------------------------
    phase_t      dec_phase;
    logic [3:0]  hdr_pos;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] img_depth;
    logic [2:0]  img_channels;
    logic [2:0]  pkt_pos;
    logic [7:0]  pkt_buf [0:4];
    logic [33:0] img_total;             // width * height * channels, in bytes
    logic [33:0] img_filled;            // bytes covered by runs so far
    bit          byte_live;             // last byte was parsed, not dropped

    function automatic void parser_clear();
        dec_phase    = PH_HEADER;
        hdr_pos      = '0;
        img_width    = '0;
        img_height   = '0;
        img_depth    = '0;
        img_channels = CH_NONE;
        pkt_pos      = '0;
        foreach (pkt_buf[i]) pkt_buf[i] = '0;
        img_total    = '0;
        img_filled   = '0;
    endfunction

    function automatic out_t pack_result(input logic [1:0] kind, input logic [7:0] run,
                                         input logic [7:0] red, green, blue, alpha,
                                         input logic done, input logic [1:0] err);
        out_t r;
        r.kind          = kind;
        r.width         = img_width;
        r.height        = img_height;
        r.channels      = img_channels;
        r.run_length    = run;
        r.red           = red;
        r.green         = green;
        r.blue          = blue;
        r.alpha_or_gray = alpha;
        r.image_done    = done;
        r.error_code    = err;
        return r;
    endfunction

    // Advance the model by one byte; returns 1 when the byte yields a result
    function automatic bit decode_byte(input in_t item, output out_t res);
        logic [7:0] b;
        logic [3:0] pos;
        logic [2:0] pkt_len;
        logic [7:0] count;
        logic       done;
        res = '0;
        b   = item.data_byte;
        if (item.start_of_file)
            parser_clear();
        byte_live = (dec_phase != PH_IDLE);

        if (dec_phase == PH_HEADER) begin
            pos = hdr_pos;
            if (pos <= HDR_WIDTH_LO)
                img_width = {img_width[7:0], b};
            else if (pos <= HDR_HEIGHT_LO)
                img_height = {img_height[7:0], b};
            else if (pos >= HDR_DEPTH_HI)
                img_depth = {img_depth[7:0], b};
            hdr_pos = pos + 4'd1;
            if (pos != HDR_DEPTH_LO)
                return 1'b0;
            case (img_depth)
                DEPTH_GRAY: img_channels = CH_GRAY;
                DEPTH_RGB:  img_channels = CH_RGB;
                DEPTH_RGBA: img_channels = CH_RGBA;
                default: begin
                    img_channels = CH_NONE;
                    dec_phase    = PH_IDLE;
                    res = pack_result(KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, ERR_BAD_DEPTH);
                    return 1'b1;
                end
            endcase
            img_total  = 34'(img_width) * 34'(img_height) * 34'(img_channels);
            img_filled = '0;
            pkt_pos    = '0;
            dec_phase  = (img_total == 0) ? PH_IDLE : PH_RUNS;
            res = pack_result(KIND_HEADER, 0, 0, 0, 0, 0, img_total == 0, ERR_NONE);
            return 1'b1;
        end

        if (dec_phase != PH_RUNS)
            return 1'b0;

        // count byte plus one byte per channel
        pkt_len = img_channels + 3'd1;
        pkt_buf[pkt_pos % 5] = b;
        pkt_pos = pkt_pos + 3'd1;
        if (pkt_pos < pkt_len)
            return 1'b0;
        pkt_pos = '0;

        count      = pkt_buf[PKT_COUNT];
        img_filled = img_filled + 34'(count) * 34'(img_channels);
        if (img_filled > img_total) begin
            dec_phase = PH_IDLE;
            res = pack_result(KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, ERR_OVERFLOW);
            return 1'b1;
        end
        done = (img_filled == img_total);
        if (done)
            dec_phase = PH_IDLE;
        if (img_channels == CH_GRAY)
            res = pack_result(KIND_RUN, count, 0, 0, 0, pkt_buf[PKT_BLUE], done, ERR_NONE);
        else
            res = pack_result(KIND_RUN, count, pkt_buf[PKT_RED], pkt_buf[PKT_GREEN],
                              pkt_buf[PKT_BLUE],
                              (img_channels == CH_RGBA) ? pkt_buf[PKT_ALPHA] : 8'h00,
                              done, ERR_NONE);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call, entered and left on a rising edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sof);
        in_t  item;
        out_t res;
        item.data_byte     = b;
        item.start_of_file = sof;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // transfer taken at this edge
        if (decode_byte(item, res))
            expected_results.push_back(res);
        if (byte_live)
            live_bytes++;
    endtask

    // Ten-byte header; the four unused bytes alternate skip and its inverse
    task automatic send_header(input logic sof, input logic [15:0] w, h, depth,
                               input logic [7:0] skip);
        send_byte(w[15:8], sof);
        send_byte(w[7:0], 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        repeat (2) begin
            send_byte(skip, 1'b0);
            send_byte(~skip, 1'b0);
        end
        send_byte(depth[15:8], 1'b0);
        send_byte(depth[7:0], 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern, long stall on request, and the checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string field, input int unsigned want, got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("kind",          oldest_result.kind,          m_data.kind);
                check_field("width",         oldest_result.width,         m_data.width);
                check_field("height",        oldest_result.height,        m_data.height);
                check_field("channels",      oldest_result.channels,      m_data.channels);
                check_field("run_length",    oldest_result.run_length,    m_data.run_length);
                check_field("red",           oldest_result.red,           m_data.red);
                check_field("green",         oldest_result.green,         m_data.green);
                check_field("blue",          oldest_result.blue,          m_data.blue);
                check_field("alpha_or_gray", oldest_result.alpha_or_gray, m_data.alpha_or_gray);
                check_field("image_done",    oldest_result.image_done,    m_data.image_done);
                check_field("error_code",    oldest_result.error_code,    m_data.error_code);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No start flag after reset: 1x1 RGBA, a zero-length run, the filling run, then a
    // byte that must be dropped once the image is complete
    task automatic test_headerless_file();
        send_header(1'b0, 16'd1, 16'd1, DEPTH_RGBA, 8'hFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Zero height: header reports done straight away, following bytes dropped
    task automatic test_empty_image();
        send_header(1'b1, 16'hFFFF, 16'h0000, DEPTH_GRAY, 8'h00);
        send_byte(8'h55, 1'b0);
    endtask

    // Unsupported depth at the largest geometry: error, then bytes dropped
    task automatic test_bad_depth();
        send_header(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hA5);
        send_byte(8'h08, 1'b0);
    endtask

    // Header abandoned by a fresh start flag, then a 255-pixel run into a 1x1 RGB image
    task automatic test_restart_and_overflow();
        send_byte(8'h00, 1'b1);
        send_byte(8'h07, 1'b0);
        send_byte(8'h00, 1'b0);
        send_header(1'b1, 16'd1, 16'd1, DEPTH_RGB, 8'h5A);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // One random file: mostly small well-formed images, some empty, huge or bad-depth,
    // some with overflowing runs, trailing noise, truncation or a missing start flag
    task automatic send_random_file();
        logic [7:0]  file_bytes[$];
        int unsigned roll, w, h, depth, chans, left, n, cut, pkts;
        logic        lead_sof;
        roll = $urandom_range(99);
        if (roll < 70) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
        end else if (roll < 78) begin
            w = $urandom_range(0, 3);
            h = (w == 0) ? $urandom_range(0, 3) : 0;
        end else if (roll < 92) begin
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
        end else begin
            w = 65535;
            h = 65535;
        end
        roll = $urandom_range(99);
        if (roll < 30)      depth = DEPTH_GRAY;
        else if (roll < 60) depth = DEPTH_RGB;
        else if (roll < 88) depth = DEPTH_RGBA;
        else                depth = $urandom_range(0, 65535);
        chans = (depth == DEPTH_GRAY) ? CH_GRAY :
                (depth == DEPTH_RGB)  ? CH_RGB  :
                (depth == DEPTH_RGBA) ? CH_RGBA : CH_NONE;

        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(h[7:0]);
        repeat (4) file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(depth[15:8]);
        file_bytes.push_back(depth[7:0]);

        left = w * h;
        if (chans != CH_NONE) begin
            for (pkts = 0; pkts < 12 && left != 0; pkts++) begin
                roll = $urandom_range(99);
                if (roll < 8)
                    n = 0;
                else if (roll < 16 && left < 255)
                    n = $urandom_range(left + 1, 255);
                else
                    n = $urandom_range(1, (left < 255) ? left : 255);
                file_bytes.push_back(8'(n));
                repeat (chans) file_bytes.push_back(8'($urandom_range(255)));
                left = (n > left) ? 0 : left - n;
            end
        end
        if ($urandom_range(99) < 50)
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(255)));
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(1, file_bytes.size());
            file_bytes = file_bytes[0:cut-1];
        end

        lead_sof = ($urandom_range(99) < 95);
        foreach (file_bytes[i])
            send_byte(file_bytes[i], (i == 0) ? lead_sof : 1'b0);
    endtask

    task automatic test_random_files(input int unsigned sender_pct, receiver_pct, items);
        int unsigned goal;
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
        goal = live_bytes + items;
        while (live_bytes < goal)
            send_random_file();
    endtask

    // Receiver stalls for a long stretch while short gray packets keep coming, so the
    // result buffer fills and s_ready has to drop
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_token    <= hold_token + 1;
        send_header(1'b1, 16'h00FF, 16'h00FF, DEPTH_GRAY, 8'h3C);
        repeat (40) begin
            send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        parser_clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_headerless_file();
        test_empty_image();
        test_bad_depth();
        test_restart_and_overflow();
        test_random_files(28, 46, 90);
        test_random_files(46, 28, 90);
        test_result_backpressure();
        test_random_files(0, 0, 90);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("pix_run_length_image_decoder_unit regression: pass");
        else
            $display("pix_run_length_image_decoder_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("pix_run_length_image_decoder_unit regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/prle_pkg.sv
design/prle_out_buf.sv
design/pix_run_length_image_decoder_unit.sv
design/prle_checker.sv
bench/tb_pix_run_length_image_decoder_unit.sv
